// ===== design/assert_macros.svh =====
// Assertion macros used by the edge assigner datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked at every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lbea_pkg.sv =====
// Package: widths, register map, reset values and control types of the edge assigner.
`timescale 1ns / 1ps

package lbea_pkg;

	localparam int unsigned PARTS_DEF    = 16;
	localparam int unsigned VERTICES_DEF = 65536;

	localparam int VID_W  = 16;  // vertex id
	localparam int PART_W = 4;   // partition number on the channels
	localparam int LOAD_W = 32;  // load counter and limit
	localparam int PCNT_W = 5;   // parts_in_use register
	localparam int CFG_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [LOAD_W-1:0] MAX_LOAD_RST     = '1;
	localparam logic [PCNT_W-1:0] PARTS_IN_USE_RST = 5'd16;

	typedef enum logic {
		REG_MAX_LOAD     = 1'b0,
		REG_PARTS_IN_USE = 1'b1
	} reg_idx_t;

	// Commands from the sequencer to the datapath, one step each.
	typedef struct packed {
		logic clr;
		logic capture;
		logic mul1;
		logic mul2;
		logic decide;
		logic rd_src;
		logic rd_dst;
		logic wr_src;
		logic wr_dst;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} status_t;

endpackage

// ===== design/lbea_ifs.sv =====
// Stream interfaces: edge items in, assignment results out.
`timescale 1ns / 1ps

interface lbea_edge_if import lbea_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VID_W-1:0]  src_vertex;
	logic [VID_W-1:0]  dest_vertex;
	logic [PART_W-1:0] src_part;
	logic [PART_W-1:0] dest_part;
	logic              in_big;

	modport source (output valid, src_vertex, dest_vertex, src_part, dest_part, in_big,
		input ready);
	modport sink (input valid, src_vertex, dest_vertex, src_part, dest_part, in_big,
		output ready);
endinterface

interface lbea_result_if import lbea_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PART_W-1:0] chosen_part;
	logic              no_room;
	logic              src_replica_new;
	logic              dest_replica_new;

	modport source (output valid, chosen_part, no_room, src_replica_new, dest_replica_new,
		input ready);
	modport sink (input valid, chosen_part, no_room, src_replica_new, dest_replica_new,
		output ready);
endinterface

// ===== design/lbea_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lbea_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/lbea_cfg.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module lbea_cfg import lbea_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [LOAD_W-1:0] max_load,
	output logic [PCNT_W-1:0] parts_in_use
);

	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	logic [LOAD_W-1:0] max_load_q;
	logic [PCNT_W-1:0] parts_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_load_q     <= MAX_LOAD_RST;
			parts_in_use_q <= PARTS_IN_USE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MAX_LOAD:     max_load_q     <= pwdata[LOAD_W-1:0];
				REG_PARTS_IN_USE: parts_in_use_q <= pwdata[PCNT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_LOAD:     prdata = APB_DW'(max_load_q);
			REG_PARTS_IN_USE: prdata = APB_DW'(parts_in_use_q);
			default:          prdata = '0;
		endcase
	end

	assign max_load     = max_load_q;
	assign parts_in_use = parts_in_use_q;

endmodule

// ===== design/lbea_ctrl.sv =====
// Sequencer: replica clearing pass, then one edge at a time through the datapath steps.
`timescale 1ns / 1ps

module lbea_ctrl import lbea_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b00_0000_0001,
		ST_IDLE  = 10'b00_0000_0010,
		ST_MUL1  = 10'b00_0000_0100,
		ST_MUL2  = 10'b00_0000_1000,
		ST_MOD   = 10'b00_0001_0000,
		ST_RDS   = 10'b00_0010_0000,
		ST_RDD   = 10'b00_0100_0000,
		ST_WRS   = 10'b00_1000_0000,
		ST_WRD   = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_MOD;
			end
			ST_MOD: begin
				cmd.decide = 1'b1;
				state_d    = ST_RDS;
			end
			ST_RDS: begin
				cmd.rd_src = 1'b1;
				state_d    = ST_RDD;
			end
			ST_RDD: begin
				cmd.rd_dst = 1'b1;
				state_d    = ST_WRS;
			end
			ST_WRS: begin
				cmd.wr_src = 1'b1;
				state_d    = ST_WRD;
			end
			ST_WRD: begin
				cmd.wr_dst = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				// hold here while the previous result still waits
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== design/lbea_dp.sv =====
// Datapath: vertex index reduction, load counters, partition choice, replica update, result.
`timescale 1ns / 1ps

module lbea_dp import lbea_pkg::*; #(
	parameter int unsigned PARTS    = PARTS_DEF,
	parameter int unsigned VERTICES = VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic [LOAD_W-1:0] max_load,
	input  logic [PCNT_W-1:0] parts_in_use,
	input  logic [VID_W-1:0]  src_vertex,
	input  logic [VID_W-1:0]  dest_vertex,
	input  logic [PART_W-1:0] src_part,
	input  logic [PART_W-1:0] dest_part,
	input  logic              in_big,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PART_W-1:0] chosen_part,
	output logic              no_room,
	output logic              src_replica_new,
	output logic              dest_replica_new
);

	localparam int PW  = $clog2(PARTS);
	localparam int AW  = $clog2(VERTICES);
	localparam int VW  = $clog2(VERTICES + 1);
	localparam int PRW = VID_W + VW;
	localparam int RW  = (VW > VID_W) ? VW : VID_W;
	localparam logic [63:0]   RECIP_WIDE = (64'd1 << 32) / 64'(VERTICES);
	localparam logic [31:0]   RECIP      = RECIP_WIDE[31:0];
	localparam logic [VW-1:0] VCONST     = VW'(VERTICES);

	// ---------------- captured item ----------------
	logic [VID_W-1:0]  sv_q, dv_q;
	logic [PART_W-1:0] sp_raw_q, dp_raw_q;
	logic              big_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sv_q     <= src_vertex;
			dv_q     <= dest_vertex;
			sp_raw_q <= src_part;
			dp_raw_q <= dest_part;
			big_q    <= in_big;
		end
	end

	// ---------------- effective partition count ----------------
	logic [7:0] pin8, n8, sp8, dp8, sps8, dps8;

	always_comb begin
		pin8 = 8'(parts_in_use);
		if (pin8 > 8'(PARTS)) begin
			n8 = 8'(PARTS);
		end else if (pin8 == 8'd0) begin
			n8 = 8'd1;
		end else begin
			n8 = pin8;
		end
		sp8  = 8'(sp_raw_q);
		dp8  = 8'(dp_raw_q);
		sps8 = (sp8 >= n8) ? n8 - 8'd1 : sp8;
		dps8 = (dp8 >= n8) ? n8 - 8'd1 : dp8;
	end

	// ---------------- vertex id modulo VERTICES, by reciprocal ----------------
	logic [47:0]      ms_src, ms_dst;
	logic [PRW-1:0]   ps_src, ps_dst;
	logic [VID_W-1:0] qs_q, qd_q, prs_q, prd_q;
	logic [PW-1:0]    sp_q, dp_q;
	logic [VID_W-1:0] diff_src, diff_dst;
	logic [RW-1:0]    rs_ext, rd_ext, rs_sel, rd_sel;
	logic [AW-1:0]    rs_q, rd_q;

	assign ms_src = 48'(sv_q) * 48'(RECIP);
	assign ms_dst = 48'(dv_q) * 48'(RECIP);
	assign ps_src = PRW'(qs_q) * PRW'(VCONST);
	assign ps_dst = PRW'(qd_q) * PRW'(VCONST);

	// the quotient estimate is at most one low, so one subtract corrects it
	assign diff_src = sv_q - prs_q;
	assign diff_dst = dv_q - prd_q;
	assign rs_ext   = RW'(diff_src);
	assign rd_ext   = RW'(diff_dst);
	assign rs_sel   = (rs_ext >= RW'(VCONST)) ? rs_ext - RW'(VCONST) : rs_ext;
	assign rd_sel   = (rd_ext >= RW'(VCONST)) ? rd_ext - RW'(VCONST) : rd_ext;

	// ---------------- load counters ----------------
	logic [LOAD_W-1:0] load_q [PARTS];
	logic [PARTS-1:0]  full_q;
	logic [LOAD_W-1:0] lds_q, ldd_q;
	logic [PW-1:0]     chosen_q;
	logic              found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PARTS; p++) begin
				load_q[p] <= '0;
			end
			full_q <= '0;
		end else begin
			for (int p = 0; p < PARTS; p++) begin
				full_q[p] <= (load_q[p] > max_load);
				// saturate at all ones
				if (cmd.wr_dst && found_q && (chosen_q == PW'(p)) && (load_q[p] != '1)) begin
					load_q[p] <= load_q[p] + LOAD_W'(1);
				end
			end
		end
	end

	// ---------------- fallback search over free partitions ----------------
	logic [PARTS-1:0] free;
	logic             any_free;
	logic [PW-1:0]    up_idx, dn_idx;

	always_comb begin
		any_free = 1'b0;
		up_idx   = '0;
		dn_idx   = '0;
		for (int p = 0; p < PARTS; p++) begin
			free[p] = !full_q[p] && (8'(p) < n8);
		end
		for (int p = PARTS - 1; p >= 0; p--) begin
			if (free[p]) begin
				up_idx   = PW'(p);
				any_free = 1'b1;
			end
		end
		for (int p = 0; p < PARTS; p++) begin
			if (free[p]) dn_idx = PW'(p);
		end
	end

	logic both_full;
	assign both_full = full_q[sp_q] && full_q[dp_q];

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			qs_q <= ms_src[47:32];
			qd_q <= ms_dst[47:32];
			sp_q <= PW'(sps8);
			dp_q <= PW'(dps8);
		end
		if (cmd.mul2) begin
			prs_q <= ps_src[VID_W-1:0];
			prd_q <= ps_dst[VID_W-1:0];
			lds_q <= load_q[sp_q];
			ldd_q <= load_q[dp_q];
		end
		if (cmd.decide) begin
			rs_q <= AW'(rs_sel);
			rd_q <= AW'(rd_sel);
			if (both_full) begin
				found_q  <= any_free;
				chosen_q <= any_free ? (big_q ? up_idx : dn_idx) : '0;
			end else begin
				found_q  <= 1'b1;
				chosen_q <= (lds_q > ldd_q) ? dp_q : sp_q;  // ties go to the source
			end
		end
	end

	// ---------------- replica memory ----------------
	logic [AW-1:0]    clr_addr_q;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [PARTS-1:0] ram_wdata, ram_rdata;
	logic [PARTS-1:0] part_bit, src_old_q, dst_old_q, src_new, dst_eff, dst_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign status.clr_last = (clr_addr_q == AW'(VERTICES - 1));

	assign part_bit = {{(PARTS - 1){1'b0}}, 1'b1} << chosen_q;
	assign src_new  = src_old_q | part_bit;
	// self-loop: the destination sees the source's mark
	assign dst_eff  = (rs_q == rd_q) ? src_new : dst_old_q;
	assign dst_new  = dst_eff | part_bit;

	assign ram_we    = cmd.clr || ((cmd.wr_src || cmd.wr_dst) && found_q);
	assign ram_waddr = cmd.clr ? clr_addr_q : (cmd.wr_src ? rs_q : rd_q);
	assign ram_wdata = cmd.clr ? '0 : (cmd.wr_src ? src_new : dst_new);
	assign ram_re    = cmd.rd_src || cmd.rd_dst;
	assign ram_raddr = cmd.rd_src ? rs_q : rd_q;

	lbea_ram #(
		.WIDTH (PARTS),
		.DEPTH (VERTICES)
	) u_replica_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic sn_q, dn_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_dst) begin
			src_old_q <= ram_rdata;
		end
		if (cmd.wr_src) begin
			dst_old_q <= ram_rdata;
		end
		if (cmd.wr_dst) begin
			sn_q <= found_q && !(|(src_old_q & part_bit));
			dn_q <= found_q && !(|(dst_eff & part_bit));
		end
	end

	// ---------------- result register ----------------
	logic       out_valid_q;
	logic [7:0] chosen_ext;

	assign chosen_ext      = 8'(chosen_q);
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			chosen_part      <= found_q ? chosen_ext[PART_W-1:0] : '0;
			no_room          <= !found_q;
			src_replica_new  <= sn_q;
			dest_replica_new <= dn_q;
		end
	end

	assign out_valid = out_valid_q;

`include "assert_macros.svh"

	`ASSERT_SAME(a_chosen_in_use, cmd.rd_src, !found_q || (8'(chosen_q) < n8), "chosen partition out of use")
	`ASSERT_SAME(a_candidate_pick, cmd.rd_src && found_q && !both_full, (chosen_q == sp_q) || (chosen_q == dp_q), "free candidate not taken")
	`ASSERT_NEXT(a_self_loop_dest, cmd.wr_dst && (rs_q == rd_q), !dn_q, "self-loop marked destination as new")

endmodule

// ===== design/load_balanced_edge_assigner_unit.sv =====
// Top level of the load-balanced edge assigner.
//
//   channel   | direction | handshake       | payload
//   ----------+-----------+-----------------+------------------------------------------------
//   edges     | in        | valid / ready   | src_vertex, dest_vertex, src_part, dest_part, in_big
//   results   | out       | valid / ready   | chosen_part, no_room, src_replica_new, dest_replica_new
//   apb       | in        | psel / penable  | paddr, pwdata, prdata (max_load @0, parts_in_use @4)
//
// Edges are taken one at a time: two reciprocal multiplies, the choice, then two reads and two
// writes through the replica memory (one read port, one write port), each a step of its own.
// After reset the replica memory is swept clean, one entry a cycle, with edges.ready low;
// configuration writes are taken during the sweep.
// A result waits in the output register; the next edge is taken meanwhile, and its result
// holds in the last step until that register frees.
`timescale 1ns / 1ps

module load_balanced_edge_assigner_unit import lbea_pkg::*; #(
	parameter int unsigned PARTS    = PARTS_DEF,
	parameter int unsigned VERTICES = VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lbea_edge_if.sink         edges,
	lbea_result_if.source     results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cmd_t              cmd;
	status_t           status;
	logic [LOAD_W-1:0] max_load;
	logic [PCNT_W-1:0] parts_in_use;

	lbea_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.max_load     (max_load),
		.parts_in_use (parts_in_use)
	);

	lbea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (edges.valid),
		.in_ready (edges.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lbea_dp #(
		.PARTS    (PARTS),
		.VERTICES (VERTICES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.max_load         (max_load),
		.parts_in_use     (parts_in_use),
		.src_vertex       (edges.src_vertex),
		.dest_vertex      (edges.dest_vertex),
		.src_part         (edges.src_part),
		.dest_part        (edges.dest_part),
		.in_big           (edges.in_big),
		.out_valid        (results.valid),
		.out_ready        (results.ready),
		.chosen_part      (results.chosen_part),
		.no_room          (results.no_room),
		.src_replica_new  (results.src_replica_new),
		.dest_replica_new (results.dest_replica_new)
	);

endmodule

// ===== test/tb_top.sv =====
// Testbench of the edge assigner: directed table, then phases of random edges under varied limits.
`timescale 1ns / 1ps

module tb_top import lbea_pkg::*; ();

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 20;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 54;

	typedef struct packed {
		logic [VID_W-1:0]  src_vertex;
		logic [VID_W-1:0]  dest_vertex;
		logic [PART_W-1:0] src_part;
		logic [PART_W-1:0] dest_part;
		logic              in_big;
	} edge_t;

	typedef struct packed {
		logic [PART_W-1:0] chosen_part;
		logic              no_room;
		logic              src_replica_new;
		logic              dest_replica_new;
	} placement_t;

	typedef struct {
		bit         is_cfg;
		reg_idx_t   reg_sel;
		logic [31:0] value;
		edge_t      e;
		bit         typed;
		placement_t want;
	} step_t;

	typedef enum {LIMIT_ZERO, LIMIT_TOP, LIMIT_NEAR} limit_mode_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	lbea_edge_if   edges_if ();
	lbea_result_if results_if ();

	load_balanced_edge_assigner_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.edges   (edges_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Own copy of the block's state and registers
	logic [LOAD_W-1:0]       load_limit;
	logic [PCNT_W-1:0]       part_count;
	logic [LOAD_W-1:0]       part_loads [PARTS_DEF];
	bit   [PARTS_DEF-1:0]    replica_bits [VERTICES_DEF];

	placement_t placements_due [$];
	step_t      directed [$];
	int         mismatches = 0;
	int         cycles = 0;
	int         pending_gap = 1;
	int         stall_left = 0;
	bit         steady = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int unsigned live_parts();
		int unsigned n;
		n = 32'(part_count);
		if (n > PARTS_DEF) n = PARTS_DEF;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic placement_t place_edge(edge_t e);
		int unsigned n;
		int unsigned sp;
		int unsigned dp;
		int unsigned p;
		int unsigned chosen;
		bit found;
		placement_t res;
		n = live_parts();
		sp = 32'(e.src_part);
		dp = 32'(e.dest_part);
		chosen = 0;
		found = 1'b1;
		if (sp >= n) sp = n - 1;
		if (dp >= n) dp = n - 1;
		if (part_loads[sp] > load_limit && part_loads[dp] > load_limit) begin
			found = 1'b0;
			for (int i = 0; i < n; i++) begin
				p = e.in_big ? i : n - 1 - i;
				if (!found && part_loads[p] <= load_limit) begin
					chosen = p;
					found = 1'b1;
				end
			end
		end else if (part_loads[sp] > part_loads[dp]) begin
			chosen = dp;
		end else begin
			chosen = sp;
		end
		res = '0;
		if (!found) begin
			res.no_room = 1'b1;
			return res;
		end
		if (part_loads[chosen] != '1) part_loads[chosen]++;
		res.chosen_part = chosen[PART_W-1:0];
		res.src_replica_new = !replica_bits[e.src_vertex][chosen];
		replica_bits[e.src_vertex][chosen] = 1'b1;
		res.dest_replica_new = !replica_bits[e.dest_vertex][chosen];
		replica_bits[e.dest_vertex][chosen] = 1'b1;
		return res;
	endfunction

	function automatic logic [LOAD_W-1:0] lowest_load();
		logic [LOAD_W-1:0] m;
		m = '1;
		for (int i = 0; i < live_parts(); i++)
			if (part_loads[i] < m) m = part_loads[i];
		return m;
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [VID_W-1:0] pick_vertex();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return VID_W'($urandom_range(0, 31));
		if (r < 8) return r[0] ? '1 : '0;
		return VID_W'($urandom);
	endfunction

	function automatic edge_t make_edge();
		edge_t e;
		e.src_vertex = pick_vertex();
		e.dest_vertex = ($urandom_range(0, 9) == 0) ? e.src_vertex : pick_vertex();
		e.src_part = ($urandom_range(0, 9) < 7) ? PART_W'($urandom_range(0, live_parts() - 1))
			: PART_W'($urandom);
		e.dest_part = ($urandom_range(0, 9) < 7) ? PART_W'($urandom_range(0, live_parts() - 1))
			: PART_W'($urandom);
		e.in_big = 1'($urandom_range(0, 1));
		return e;
	endfunction

	function automatic step_t edge_row(logic [VID_W-1:0] s, logic [VID_W-1:0] d,
		logic [PART_W-1:0] sp, logic [PART_W-1:0] dp, logic big, bit typed, placement_t want);
		step_t row;
		row.is_cfg = 1'b0;
		row.reg_sel = REG_MAX_LOAD;
		row.value = '0;
		row.e = '{s, d, sp, dp, big};
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic step_t cfg_row(reg_idx_t r, logic [31:0] v);
		step_t row;
		row.is_cfg = 1'b1;
		row.reg_sel = r;
		row.value = v;
		row.e = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		$display("%0t mismatch on %s: want %0h got %0h", $time, what, want, got);
	endtask

	task automatic cfg_write(reg_idx_t r, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(4 * int'(r));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r == REG_MAX_LOAD) load_limit = v;
		else part_count = v[PCNT_W-1:0];
	endtask

	task automatic send_edge(edge_t e, bit typed, placement_t want);
		placement_t got;
		repeat (pending_gap) @(posedge clk);
		edges_if.valid <= 1'b1;
		edges_if.src_vertex <= e.src_vertex;
		edges_if.dest_vertex <= e.dest_vertex;
		edges_if.src_part <= e.src_part;
		edges_if.dest_part <= e.dest_part;
		edges_if.in_big <= e.in_big;
		@(posedge clk);
		while (!edges_if.ready) @(posedge clk);
		got = place_edge(e);
		placements_due.push_back(typed ? want : got);
		// hold valid high only when the next transfer follows at once
		pending_gap = pick_pause();
		if (pending_gap != 0) edges_if.valid <= 1'b0;
	endtask

	task automatic stop_edges();
		if (pending_gap == 0) begin
			edges_if.valid <= 1'b0;
			pending_gap = 1;
		end
	endtask

	task automatic wait_drained();
		while (placements_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Result side: check each transfer, then choose the next ready
	always @(posedge clk) begin : result_check
		placement_t w;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (placements_due.size() == 0) begin
				report_mismatch("unexpected result", '0, 32'(results_if.chosen_part));
			end else begin
				w = placements_due.pop_front();
				if (results_if.chosen_part !== w.chosen_part)
					report_mismatch("chosen_part", 32'(w.chosen_part),
						32'(results_if.chosen_part));
				if (results_if.no_room !== w.no_room)
					report_mismatch("no_room", 32'(w.no_room), 32'(results_if.no_room));
				if (results_if.src_replica_new !== w.src_replica_new)
					report_mismatch("src_replica_new", 32'(w.src_replica_new),
						32'(results_if.src_replica_new));
				if (results_if.dest_replica_new !== w.dest_replica_new)
					report_mismatch("dest_replica_new", 32'(w.dest_replica_new),
						32'(results_if.dest_replica_new));
			end
		end
		if (stall_left > 0) begin
			results_if.ready <= 1'b0;
			stall_left--;
		end else begin
			results_if.ready <= 1'b1;
			stall_left = pick_pause();
		end
	end

	initial begin
		int unsigned phase_parts [PHASES];
		limit_mode_t phase_limit [PHASES];
		int pause_at;
		logic [31:0] parts_val;
		logic [31:0] limit_val;
		phase_parts = '{31, 4, 1, 0, 2, 16, 9, 0};
		phase_limit = '{LIMIT_ZERO, LIMIT_NEAR, LIMIT_TOP, LIMIT_NEAR, LIMIT_NEAR, LIMIT_NEAR,
			LIMIT_TOP, LIMIT_NEAR};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		edges_if.valid <= 1'b0;
		edges_if.src_vertex <= '0;
		edges_if.dest_vertex <= '0;
		edges_if.src_part <= '0;
		edges_if.dest_part <= '0;
		edges_if.in_big <= 1'b0;
		load_limit = MAX_LOAD_RST;
		part_count = PARTS_IN_USE_RST;
		foreach (part_loads[i]) part_loads[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh partitions: ties go to the source, both ends gain a replica
		directed.push_back(edge_row(16'h0000, 16'hFFFF, 4'h0, 4'hF, 1'b1, 1'b1,
			'{4'h0, 1'b0, 1'b1, 1'b1}));
		directed.push_back(edge_row(16'h0000, 16'hFFFF, 4'hF, 4'h0, 1'b0, 1'b1,
			'{4'hF, 1'b0, 1'b1, 1'b1}));
		// Self-loop marks the source first; repeating it adds no replica
		directed.push_back(edge_row(16'd7, 16'd7, 4'd3, 4'd3, 1'b1, 1'b1,
			'{4'd3, 1'b0, 1'b1, 1'b0}));
		directed.push_back(edge_row(16'd7, 16'd7, 4'd3, 4'd3, 1'b0, 1'b1,
			'{4'd3, 1'b0, 1'b0, 1'b0}));
		directed.push_back(edge_row(16'd1, 16'd2, 4'd3, 4'd4, 1'b1, 1'b0, '0));
		directed.push_back(edge_row(16'hAAAA, 16'h5555, 4'hA, 4'h5, 1'b0, 1'b0, '0));
		// Partition count of zero acts as one: every candidate folds onto partition 0
		directed.push_back(cfg_row(REG_PARTS_IN_USE, 32'd0));
		directed.push_back(edge_row(16'd9, 16'd10, 4'hF, 4'd7, 1'b1, 1'b1,
			'{4'h0, 1'b0, 1'b1, 1'b1}));
		// Zero limit: loaded partitions are full, scan both ways
		directed.push_back(cfg_row(REG_PARTS_IN_USE, 32'd31));
		directed.push_back(cfg_row(REG_MAX_LOAD, 32'd0));
		directed.push_back(edge_row(16'd20, 16'd21, 4'd0, 4'd3, 1'b1, 1'b0, '0));
		directed.push_back(edge_row(16'd20, 16'd21, 4'd0, 4'd3, 1'b0, 1'b0, '0));
		directed.push_back(edge_row(16'd22, 16'd23, 4'd0, 4'd2, 1'b1, 1'b0, '0));
		directed.push_back(edge_row(16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 1'b1, 1'b0, '0));
		// Two partitions, both loaded: no room anywhere
		directed.push_back(cfg_row(REG_PARTS_IN_USE, 32'd2));
		directed.push_back(edge_row(16'd30, 16'd31, 4'd0, 4'd1, 1'b1, 1'b1,
			'{4'h0, 1'b1, 1'b0, 1'b0}));
		directed.push_back(edge_row(16'd30, 16'd31, 4'hF, 4'hF, 1'b0, 1'b1,
			'{4'h0, 1'b1, 1'b0, 1'b0}));
		directed.push_back(cfg_row(REG_MAX_LOAD, 32'd1));
		directed.push_back(edge_row(16'd30, 16'd31, 4'd0, 4'd0, 1'b0, 1'b0, '0));
		directed.push_back(cfg_row(REG_MAX_LOAD, 32'hFFFF_FFFF));
		directed.push_back(cfg_row(REG_PARTS_IN_USE, 32'd16));
		directed.push_back(edge_row(16'hFFFF, 16'h0000, 4'hF, 4'h0, 1'b1, 1'b0, '0));

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				stop_edges();
				wait_drained();
				cfg_write(directed[i].reg_sel, directed[i].value);
			end else begin
				send_edge(directed[i].e, directed[i].typed, directed[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			stop_edges();
			wait_drained();
			parts_val = (ph == PHASES - 1) ? $urandom_range(0, 31) : phase_parts[ph];
			cfg_write(REG_PARTS_IN_USE, parts_val);
			case (phase_limit[ph])
				LIMIT_ZERO: begin
					limit_val = '0;
				end
				LIMIT_TOP: begin
					limit_val = '1;
				end
				default: begin
					limit_val = lowest_load() + $urandom_range(0, 4);
				end
			endcase
			cfg_write(REG_MAX_LOAD, limit_val);
			steady = (ph == 5);
			pause_at = $urandom_range(5, 40);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// hold off the sender until every outstanding result is back
				if (k == pause_at) begin
					stop_edges();
					wait_drained();
				end
				send_edge(make_edge(), 1'b0, '0);
			end
		end

		stop_edges();
		wait_drained();
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
